/* hw/rtl/lsps_pkg.sv */
// shared types and constants of the linked stack pool
package lsps_pkg;

   localparam int FUNC_W   = 2;
   localparam int NODE_W   = 10;
   localparam int STACK_W  = 8;
   localparam int STATUS_W = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH    = 2'd0,
      FUNC_POP     = 2'd1,
      FUNC_MOVE    = 2'd2,
      FUNC_INSPECT = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE   = 2'd0,
      STATUS_PLACED = 2'd1,
      STATUS_EMPTY  = 2'd2,
      STATUS_NOP    = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EVAL_A,
      ST_EVAL_B,
      ST_PUSH_LINK,
      ST_POP_LINK,
      ST_MOVE_CLR,
      ST_DONE
   } state_type;

endpackage

/* hw/rtl/lsps_if.sv */
// request and response channel interfaces of the linked stack pool
interface lsps_req_if;
   logic                         valid;
   logic                         ready;
   logic [lsps_pkg::FUNC_W-1:0]  func;
   logic [lsps_pkg::NODE_W-1:0]  node;
   logic [lsps_pkg::STACK_W-1:0] stack_a;
   logic [lsps_pkg::STACK_W-1:0] stack_b;

   modport source (output valid, func, node, stack_a, stack_b, input ready);
   modport sink (input valid, func, node, stack_a, stack_b, output ready);
endinterface

interface lsps_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lsps_pkg::STATUS_W-1:0] status;
   logic                          stack_nonempty;
   logic [lsps_pkg::NODE_W-1:0]   bottom_node;
   logic [lsps_pkg::NODE_W-1:0]   top_node;
   logic                          above_valid;
   logic [lsps_pkg::NODE_W-1:0]   above_node;

   modport source (output valid, status, stack_nonempty, bottom_node, top_node,
                   above_valid, above_node, input ready);
   modport sink (input valid, status, stack_nonempty, bottom_node, top_node,
                 above_valid, above_node, output ready);
endinterface

/* hw/rtl/linked_stack_pool_with_splice.sv */
// Linked stack pool: NODES nodes shared by STACKS stacks, each a doubly linked list with bottom
// and top pointers kept in a stack table. A request pushes an unplaced node, pops a top, splices
// stack_a onto stack_b (emptying stack_a) or inspects a stack's ends and a node's upward link;
// each request returns one response describing the affected stack. One request is worked at a
// time by a small sequencer around four tables (stack ends, down links, up links, placed flags),
// each with one write port and one registered read port. A request is latched while idle, its
// table reads are made and the source stack's entry is evaluated; a push onto a filled stack
// needs a second write to the up-link table, a pop that leaves nodes needs the down link of the
// old top once the stack ends are read, and a move reads the destination's ends after the
// source's and clears the source in a state of its own. A held-off response stays in its
// register and no request is taken until it goes. After reset the tables are swept clear over
// max(NODES, STACKS) entries, during which no request is taken.
module linked_stack_pool_with_splice #(
   parameter int NODES  = 1024,
   parameter int STACKS = 256
) (
   input logic        clock,
   input logic        reset,
   lsps_req_if.sink   req_chan,
   lsps_rsp_if.source rsp_chan
);

   localparam int NODE_IW  = $clog2(NODES);
   localparam int NODE_XW  = (NODE_IW > lsps_pkg::NODE_W) ? NODE_IW : lsps_pkg::NODE_W;
   localparam int STACK_IW = (STACKS > 1) ? $clog2(STACKS) : 1;
   localparam int STACK_XW = (STACK_IW > lsps_pkg::STACK_W) ? STACK_IW : lsps_pkg::STACK_W;
   localparam int CLR_N    = (NODES > STACKS) ? NODES : STACKS;
   localparam int CLR_W    = $clog2(CLR_N);

   typedef logic [NODE_IW-1:0] ptr_type;

   typedef struct packed {
      logic    nonempty;
      ptr_type bottom;
      ptr_type top;
   } stk_ent_type;

   typedef struct packed {
      logic    valid;
      ptr_type ptr;
   } link_type;

   // tables
   stk_ent_type stack_mem_ff  [STACKS];
   link_type    below_mem_ff  [NODES];
   link_type    above_mem_ff  [NODES];
   logic        placed_mem_ff [NODES];

   stk_ent_type stk_rd_ff;
   link_type    below_rd_ff;
   link_type    above_rd_ff;
   logic        placed_rd_ff;

   logic [STACK_IW-1:0] stk_raddr, stk_waddr;
   logic                stk_we;
   stk_ent_type         stk_wdata;
   ptr_type             below_raddr, below_waddr;
   logic                below_we;
   link_type            below_wdata;
   ptr_type             above_raddr, above_waddr;
   logic                above_we;
   link_type            above_wdata;
   ptr_type             placed_raddr, placed_waddr;
   logic                placed_we;
   logic                placed_wdata;

   // sequencer and request registers
   lsps_pkg::state_type  state_ff, state_in;
   logic [CLR_W-1:0]     clr_cnt_ff, clr_cnt_in;
   lsps_pkg::func_type   func_ff, func_in;
   logic [NODE_XW-1:0]   node_ff, node_in;
   logic [STACK_XW-1:0]  sa_ff, sa_in;
   logic [STACK_XW-1:0]  sb_ff, sb_in;
   stk_ent_type          a_ent_ff, a_ent_in;

   // response registers
   lsps_pkg::status_type status_ff, status_in;
   stk_ent_type          res_ent_ff, res_ent_in;
   logic                 res_av_ff, res_av_in;
   ptr_type              res_an_ff, res_an_in;

   logic                node_ok, sa_ok, sb_ok;
   ptr_type             node_idx;
   logic [STACK_IW-1:0] sa_idx, sb_idx;
   stk_ent_type         sa_view, sb_view, push_ent, move_ent;
   logic                clr_last, push_go, push_link, pop_multi, move_go;

   assign node_ok  = 32'(node_ff) < 32'(NODES);
   assign sa_ok    = 32'(sa_ff) < 32'(STACKS);
   assign sb_ok    = 32'(sb_ff) < 32'(STACKS);
   assign node_idx = node_ff[NODE_IW-1:0];
   assign sa_idx   = sa_ff[STACK_IW-1:0];
   assign sb_idx   = sb_ff[STACK_IW-1:0];

   // an out-of-range stack reads as empty
   assign sa_view  = sa_ok ? stk_rd_ff : '0;
   assign sb_view  = sb_ok ? stk_rd_ff : '0;
   assign clr_last = clr_cnt_ff == CLR_W'(CLR_N - 1);

   assign push_go   = node_ok && sa_ok && !placed_rd_ff;
   assign push_link = push_go && sa_view.nonempty;
   assign pop_multi = sa_view.nonempty && (sa_view.bottom != sa_view.top);
   assign move_go   = a_ent_ff.nonempty && (sa_ff != sb_ff) && sb_ok;

   always_comb begin
      push_ent.nonempty = 1'b1;
      push_ent.bottom   = sa_view.nonempty ? sa_view.bottom : node_idx;
      push_ent.top      = node_idx;
      move_ent.nonempty = 1'b1;
      move_ent.bottom   = sb_view.nonempty ? sb_view.bottom : a_ent_ff.bottom;
      move_ent.top      = a_ent_ff.top;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lsps_pkg::ST_CLEAR: begin
            if (clr_last) state_in = lsps_pkg::ST_IDLE;
         end
         lsps_pkg::ST_IDLE: begin
            if (req_chan.valid) state_in = lsps_pkg::ST_READ;
         end
         lsps_pkg::ST_READ: begin
            state_in = lsps_pkg::ST_EVAL_A;
         end
         lsps_pkg::ST_EVAL_A: begin
            case (func_ff)
               lsps_pkg::FUNC_PUSH: begin
                  state_in = push_link ? lsps_pkg::ST_PUSH_LINK : lsps_pkg::ST_DONE;
               end
               lsps_pkg::FUNC_POP: begin
                  state_in = pop_multi ? lsps_pkg::ST_POP_LINK : lsps_pkg::ST_DONE;
               end
               lsps_pkg::FUNC_MOVE: begin
                  state_in = lsps_pkg::ST_EVAL_B;
               end
               default: begin
                  state_in = lsps_pkg::ST_DONE;
               end
            endcase
         end
         lsps_pkg::ST_EVAL_B: begin
            state_in = move_go ? lsps_pkg::ST_MOVE_CLR : lsps_pkg::ST_DONE;
         end
         lsps_pkg::ST_PUSH_LINK, lsps_pkg::ST_POP_LINK, lsps_pkg::ST_MOVE_CLR: begin
            state_in = lsps_pkg::ST_DONE;
         end
         lsps_pkg::ST_DONE: begin
            if (rsp_chan.ready) state_in = lsps_pkg::ST_IDLE;
         end
         default: begin
            state_in = lsps_pkg::ST_CLEAR;
         end
      endcase
   end

   // table accesses and register updates
   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      func_in    = func_ff;
      node_in    = node_ff;
      sa_in      = sa_ff;
      sb_in      = sb_ff;
      a_ent_in   = a_ent_ff;
      status_in  = status_ff;
      res_ent_in = res_ent_ff;
      res_av_in  = res_av_ff;
      res_an_in  = res_an_ff;

      stk_raddr    = (state_ff == lsps_pkg::ST_EVAL_A) ? sb_idx : sa_idx;
      stk_we       = 1'b0;
      stk_waddr    = sa_idx;
      stk_wdata    = '0;
      below_raddr  = sa_view.top;
      below_we     = 1'b0;
      below_waddr  = node_idx;
      below_wdata  = '0;
      above_raddr  = node_idx;
      above_we     = 1'b0;
      above_waddr  = node_idx;
      above_wdata  = '0;
      placed_raddr = node_idx;
      placed_we    = 1'b0;
      placed_waddr = node_idx;
      placed_wdata = 1'b0;

      case (state_ff)
         lsps_pkg::ST_CLEAR: begin
            clr_cnt_in   = clr_cnt_ff + CLR_W'(1);
            stk_we       = 32'(clr_cnt_ff) < 32'(STACKS);
            stk_waddr    = clr_cnt_ff[STACK_IW-1:0];
            below_we     = 32'(clr_cnt_ff) < 32'(NODES);
            below_waddr  = clr_cnt_ff[NODE_IW-1:0];
            above_we     = below_we;
            above_waddr  = below_waddr;
            placed_we    = below_we;
            placed_waddr = below_waddr;
         end
         lsps_pkg::ST_IDLE: begin
            func_in   = lsps_pkg::func_type'(req_chan.func);
            node_in   = NODE_XW'(req_chan.node);
            sa_in     = STACK_XW'(req_chan.stack_a);
            sb_in     = STACK_XW'(req_chan.stack_b);
            status_in = lsps_pkg::STATUS_DONE;
            res_av_in = 1'b0;
            res_an_in = '0;
         end
         lsps_pkg::ST_EVAL_A: begin
            a_ent_in   = sa_view;
            res_ent_in = sa_view;
            case (func_ff)
               lsps_pkg::FUNC_PUSH: begin
                  if (!node_ok || !sa_ok) begin
                     status_in = lsps_pkg::STATUS_NOP;
                  end else if (placed_rd_ff) begin
                     status_in = lsps_pkg::STATUS_PLACED;
                  end else begin
                     stk_we            = 1'b1;
                     stk_wdata         = push_ent;
                     below_we          = 1'b1;
                     below_wdata.valid = sa_view.nonempty;
                     below_wdata.ptr   = sa_view.top;
                     above_we          = 1'b1;
                     placed_we         = 1'b1;
                     placed_wdata      = 1'b1;
                     res_ent_in        = push_ent;
                  end
               end
               lsps_pkg::FUNC_POP: begin
                  if (!sa_view.nonempty) begin
                     status_in = lsps_pkg::STATUS_EMPTY;
                  end else if (!pop_multi) begin
                     // single node: stack empties, node is freed
                     stk_we       = 1'b1;
                     below_we     = 1'b1;
                     below_waddr  = sa_view.top;
                     placed_we    = 1'b1;
                     placed_waddr = sa_view.top;
                     res_ent_in   = '0;
                  end
               end
               lsps_pkg::FUNC_INSPECT: begin
                  res_av_in = node_ok && above_rd_ff.valid;
                  res_an_in = (node_ok && above_rd_ff.valid) ? above_rd_ff.ptr : '0;
               end
               default: begin
               end
            endcase
         end
         lsps_pkg::ST_EVAL_B: begin
            res_ent_in = sb_view;
            if (!move_go) begin
               status_in = lsps_pkg::STATUS_NOP;
            end else begin
               stk_we     = 1'b1;
               stk_waddr  = sb_idx;
               stk_wdata  = move_ent;
               res_ent_in = move_ent;
               if (sb_view.nonempty) begin
                  // link old top of b to bottom of a
                  above_we          = 1'b1;
                  above_waddr       = sb_view.top;
                  above_wdata.valid = 1'b1;
                  above_wdata.ptr   = a_ent_ff.bottom;
                  below_we          = 1'b1;
                  below_waddr       = a_ent_ff.bottom;
                  below_wdata.valid = 1'b1;
                  below_wdata.ptr   = sb_view.top;
               end
            end
         end
         lsps_pkg::ST_PUSH_LINK: begin
            above_we          = 1'b1;
            above_waddr       = a_ent_ff.top;
            above_wdata.valid = 1'b1;
            above_wdata.ptr   = node_idx;
         end
         lsps_pkg::ST_POP_LINK: begin
            stk_we             = 1'b1;
            stk_wdata.nonempty = 1'b1;
            stk_wdata.bottom   = a_ent_ff.bottom;
            stk_wdata.top      = below_rd_ff.ptr;
            res_ent_in         = stk_wdata;
            above_we           = 1'b1;
            above_waddr        = below_rd_ff.ptr;
            below_we           = 1'b1;
            below_waddr        = a_ent_ff.top;
            placed_we          = 1'b1;
            placed_waddr       = a_ent_ff.top;
         end
         lsps_pkg::ST_MOVE_CLR: begin
            stk_we = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= lsps_pkg::ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      node_ff    <= node_in;
      sa_ff      <= sa_in;
      sb_ff      <= sb_in;
      a_ent_ff   <= a_ent_in;
      status_ff  <= status_in;
      res_ent_ff <= res_ent_in;
      res_av_ff  <= res_av_in;
      res_an_ff  <= res_an_in;
   end

   always_ff @(posedge clock) begin
      if (stk_we) stack_mem_ff[stk_waddr] <= stk_wdata;
      stk_rd_ff <= stack_mem_ff[stk_raddr];
   end

   always_ff @(posedge clock) begin
      if (below_we) below_mem_ff[below_waddr] <= below_wdata;
      below_rd_ff <= below_mem_ff[below_raddr];
   end

   always_ff @(posedge clock) begin
      if (above_we) above_mem_ff[above_waddr] <= above_wdata;
      above_rd_ff <= above_mem_ff[above_raddr];
   end

   always_ff @(posedge clock) begin
      if (placed_we) placed_mem_ff[placed_waddr] <= placed_wdata;
      placed_rd_ff <= placed_mem_ff[placed_raddr];
   end

   assign req_chan.ready          = state_ff == lsps_pkg::ST_IDLE;
   assign rsp_chan.valid          = state_ff == lsps_pkg::ST_DONE;
   assign rsp_chan.status         = status_ff;
   assign rsp_chan.stack_nonempty = res_ent_ff.nonempty;
   assign rsp_chan.bottom_node    = lsps_pkg::NODE_W'(res_ent_ff.bottom);
   assign rsp_chan.top_node       = lsps_pkg::NODE_W'(res_ent_ff.top);
   assign rsp_chan.above_valid    = res_av_ff;
   assign rsp_chan.above_node     = lsps_pkg::NODE_W'(res_an_ff);

   // never take a request while a response is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("request taken while response pending");

   // refusal codes belong to their operations
   a_status_func: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         (status_ff != lsps_pkg::STATUS_PLACED || func_ff == lsps_pkg::FUNC_PUSH) &&
         (status_ff != lsps_pkg::STATUS_EMPTY || func_ff == lsps_pkg::FUNC_POP))
      else $error("status code does not match operation");

   // an empty stack reports zero ends
   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.stack_nonempty) |->
         (res_ent_ff.bottom == '0 && res_ent_ff.top == '0))
      else $error("empty stack with nonzero ends");

   // upward link is only reported by inspect
   a_above_inspect: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && res_av_ff) |-> func_ff == lsps_pkg::FUNC_INSPECT)
      else $error("above link reported outside inspect");

   // tables are not written between requests
   a_quiet_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lsps_pkg::ST_IDLE || state_ff == lsps_pkg::ST_DONE) |->
         !(stk_we || below_we || above_we || placed_we))
      else $error("table write while idle");

endmodule
